>>> sv/rtfp_pkg.sv
// Shared types, constants and helpers for the radar target frame parser.
// No dependencies; every other file imports this package.
package rtfp_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 30;
    localparam int IDX_W       = 5;
    localparam int MEM_AW      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 ** MEM_AW;
    localparam int SLOT_COUNT  = 3;
    localparam int SLOT_FIELDS = 6;

    // Byte positions within a frame
    localparam logic [IDX_W-1:0] IDX_SYNC_A = 5'd0;
    localparam logic [IDX_W-1:0] IDX_SYNC_B = 5'd1;
    localparam logic [IDX_W-1:0] IDX_HDR_C  = 5'd2;
    localparam logic [IDX_W-1:0] IDX_HDR_D  = 5'd3;
    localparam logic [IDX_W-1:0] SLOT_BASE  = 5'd4;
    localparam logic [IDX_W-1:0] IDX_FOOT_A = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BYTES - 1);

    // Marker bytes
    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'hFF;
    localparam logic [7:0] HDR_C  = 8'h03;
    localparam logic [7:0] HDR_D  = 8'h00;
    localparam logic [7:0] FOOT_A = 8'h55;
    localparam logic [7:0] FOOT_B = 8'hCC;
    localparam logic [15:0] MAG_MASK = 16'h7FFF;

    localparam logic [1:0] LAST_SLOT  = 2'(SLOT_COUNT - 1);
    localparam logic [2:0] LAST_FIELD = 3'(SLOT_FIELDS - 1);

    // Decoder sequencer
    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_READ,
        DEC_WAIT,
        DEC_EVAL,
        DEC_FLUSH
    } dec_state_t;

    // Collector to decoder: a good frame is ready in the given bank
    typedef struct packed {
        logic start;
        logic bank;
    } handoff_t;

    // Sign-magnitude to two's complement; bit 15 set means positive
    function automatic logic signed [15:0] sm_decode(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] raw;
        logic [15:0] mag;
        raw = {hi, lo};
        mag = raw & MAG_MASK;
        sm_decode = raw[15] ? $signed(mag) : $signed(16'd0 - mag);
    endfunction

endpackage

>>> sv/rtfp_frame_mem.sv
// Two-bank frame byte store: one write port, one read port, registered read.
// Depends on rtfp_pkg.
module rtfp_frame_mem
    import rtfp_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [MEM_AW-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [MEM_AW-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/rtfp_collector.sv
// Sync hunt and frame collection into the byte store; checks header and footer in flight.
// Depends on rtfp_pkg.
module rtfp_collector
    import rtfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    input  logic [7:0]        rx_byte,
    output logic              rx_stall,
    input  logic              dec_busy,
    output logic              wr_en,
    output logic [MEM_AW-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output handoff_t          hand
);

    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic             foot_ok_reg, foot_ok_next;
    logic             bank_reg, bank_next;
    handoff_t         hand_reg, hand_next;
    logic             accept;

    // Hold the closing byte while the other bank is still being decoded
    assign rx_stall = (fill_reg == IDX_LAST) && dec_busy;
    assign accept   = rx_valid && !rx_stall;

    assign wr_addr = {bank_reg, fill_reg};
    assign wr_data = rx_byte;
    assign hand    = hand_reg;

    // Collection sequence
    always_comb
    begin
        fill_next       = fill_reg;
        hdr_ok_next     = hdr_ok_reg;
        foot_ok_next    = foot_ok_reg;
        bank_next       = bank_reg;
        hand_next.start = 1'b0;
        hand_next.bank  = bank_reg;
        wr_en           = 1'b0;
        if (accept)
        begin
            if (fill_reg == IDX_SYNC_A)
            begin
                if (rx_byte == SYNC_A)
                begin
                    wr_en     = 1'b1;
                    fill_next = IDX_SYNC_B;
                end
            end
            else if (fill_reg == IDX_SYNC_B)
            begin
                // broken sync drops the byte without re-testing it
                if (rx_byte == SYNC_B)
                begin
                    wr_en     = 1'b1;
                    fill_next = IDX_HDR_C;
                end
                else
                begin
                    fill_next = IDX_SYNC_A;
                end
            end
            else if (fill_reg == IDX_LAST)
            begin
                wr_en     = 1'b1;
                fill_next = IDX_SYNC_A;
                if (hdr_ok_reg && foot_ok_reg && (rx_byte == FOOT_B))
                begin
                    hand_next.start = 1'b1;
                    bank_next       = ~bank_reg;
                end
            end
            else
            begin
                wr_en     = 1'b1;
                fill_next = fill_reg + 5'd1;
                if (fill_reg == IDX_HDR_C)
                begin
                    hdr_ok_next = (rx_byte == HDR_C);
                end
                if (fill_reg == IDX_HDR_D)
                begin
                    hdr_ok_next = hdr_ok_reg && (rx_byte == HDR_D);
                end
                if (fill_reg == IDX_FOOT_A)
                begin
                    foot_ok_next = (rx_byte == FOOT_A);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= IDX_SYNC_A;
            hdr_ok_reg  <= 1'b0;
            foot_ok_reg <= 1'b0;
            bank_reg    <= 1'b0;
            hand_reg    <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            hdr_ok_reg  <= hdr_ok_next;
            foot_ok_reg <= foot_ok_next;
            bank_reg    <= bank_next;
            hand_reg    <= hand_next;
        end
    end

endmodule

>>> sv/rtfp_decoder.sv
// Slot decoder: reads a finished frame bank byte by byte, skips empty slots,
// and drives the result register. Depends on rtfp_pkg.
module rtfp_decoder
    import rtfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  handoff_t           hand,
    output logic               dec_busy,
    output logic               rd_en,
    output logic [MEM_AW-1:0]  rd_addr,
    input  logic [7:0]         rd_data,
    output logic               tgt_valid,
    input  logic               tgt_stall,
    output logic [1:0]         target_number,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] target_speed,
    output logic               has_target,
    output logic               last_of_frame
);

    dec_state_t state_reg, state_next;
    logic       bank_reg, bank_next;
    logic [1:0] slot_reg, slot_next;
    logic [2:0] field_reg, field_next;
    logic       cap_vld_reg, cap_vld_next;
    logic [2:0] cap_idx_reg, cap_idx_next;
    logic [7:0] slot_bytes [SLOT_FIELDS];

    // Result held back until it is known whether it closes the frame
    logic               held_vld_reg, held_vld_next;
    logic [1:0]         held_num_reg;
    logic signed [15:0] held_x_reg, held_y_reg, held_s_reg;
    logic               held_load;

    logic               out_vld_reg, out_vld_next;
    logic [1:0]         out_num_reg;
    logic signed [15:0] out_x_reg, out_y_reg, out_s_reg;
    logic               out_has_reg, out_last_reg;

    logic               out_free;
    logic               push;
    logic               push_last;
    logic               present;
    logic [IDX_W-1:0]   rd_idx;

    assign out_free = !out_vld_reg || !tgt_stall;
    assign present  = (slot_bytes[0] != 8'd0) || (slot_bytes[1] != 8'd0) ||
                      (slot_bytes[2] != 8'd0) || (slot_bytes[3] != 8'd0);
    assign rd_idx   = SLOT_BASE + {slot_reg, 3'b000} + IDX_W'(field_reg);
    assign rd_addr  = {bank_reg, rd_idx};
    assign dec_busy = (state_reg != DEC_IDLE);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        slot_next     = slot_reg;
        field_next    = field_reg;
        cap_vld_next  = 1'b0;
        cap_idx_next  = field_reg;
        held_vld_next = held_vld_reg;
        held_load     = 1'b0;
        push          = 1'b0;
        push_last     = 1'b0;
        rd_en         = 1'b0;
        case (state_reg)
            DEC_IDLE:
            begin
                if (hand.start)
                begin
                    bank_next  = hand.bank;
                    slot_next  = 2'd0;
                    field_next = 3'd0;
                    state_next = DEC_READ;
                end
            end
            DEC_READ:
            begin
                rd_en        = 1'b1;
                cap_vld_next = 1'b1;
                if (field_reg == LAST_FIELD)
                begin
                    field_next = 3'd0;
                    state_next = DEC_WAIT;
                end
                else
                begin
                    field_next = field_reg + 3'd1;
                end
            end
            DEC_WAIT:
            begin
                state_next = DEC_EVAL;
            end
            DEC_EVAL:
            begin
                if (!(present && held_vld_reg && !out_free))
                begin
                    if (present)
                    begin
                        push          = held_vld_reg;
                        held_load     = 1'b1;
                        held_vld_next = 1'b1;
                    end
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = DEC_FLUSH;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 2'd1;
                        state_next = DEC_READ;
                    end
                end
            end
            DEC_FLUSH:
            begin
                if (out_free)
                begin
                    push          = 1'b1;
                    push_last     = 1'b1;
                    held_vld_next = 1'b0;
                    state_next    = DEC_IDLE;
                end
            end
            default:
            begin
                state_next = DEC_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        out_vld_next = out_vld_reg && tgt_stall;
        if (push)
        begin
            out_vld_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= DEC_IDLE;
            bank_reg     <= 1'b0;
            slot_reg     <= 2'd0;
            field_reg    <= 3'd0;
            cap_vld_reg  <= 1'b0;
            cap_idx_reg  <= 3'd0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            slot_reg     <= slot_next;
            field_reg    <= field_next;
            cap_vld_reg  <= cap_vld_next;
            cap_idx_reg  <= cap_idx_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Slot byte capture from the read port
    always_ff @(posedge clk)
    begin
        if (cap_vld_reg)
        begin
            slot_bytes[cap_idx_reg] <= rd_data;
        end
    end

    // Held result: decode sign-magnitude on load
    always_ff @(posedge clk)
    begin
        if (held_load)
        begin
            held_num_reg <= slot_reg + 2'd1;
            held_x_reg   <= sm_decode(slot_bytes[0], slot_bytes[1]);
            held_y_reg   <= sm_decode(slot_bytes[2], slot_bytes[3]);
            held_s_reg   <= sm_decode(slot_bytes[4], slot_bytes[5]);
        end
    end

    // Result payload; an empty frame gives an all-zero beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_last_reg <= push_last;
            out_has_reg  <= held_vld_reg;
            out_num_reg  <= held_vld_reg ? held_num_reg : 2'd0;
            out_x_reg    <= held_vld_reg ? held_x_reg : 16'sd0;
            out_y_reg    <= held_vld_reg ? held_y_reg : 16'sd0;
            out_s_reg    <= held_vld_reg ? held_s_reg : 16'sd0;
        end
    end

    assign tgt_valid     = out_vld_reg;
    assign target_number = out_num_reg;
    assign pos_x         = out_x_reg;
    assign pos_y         = out_y_reg;
    assign target_speed  = out_s_reg;
    assign has_target    = out_has_reg;
    assign last_of_frame = out_last_reg;

endmodule

>>> sv/radar_target_frame_parser_unit.sv
// Top level of the radar target frame parser: collector, two-bank store, slot decoder.
// Depends on rtfp_pkg, rtfp_frame_mem, rtfp_collector, rtfp_decoder.
//
//  channel | beat                                  | handshake
//  --------+---------------------------------------+---------------------
//  rx      | rx_byte                               | rx_valid / rx_stall
//  tgt     | target_number, pos_x, pos_y,          | tgt_valid / tgt_stall
//          | target_speed, has_target, last_of_frame|
//
// One byte is taken per cycle unless rx_stall is high. Frames fill one bank of the
// byte store while the previous good frame is decoded from the other; the decoder
// reads one byte per cycle, six per slot, and a tgt stall can hold it back. rx_stall
// rises only on the closing byte of a frame while the previous frame is still being
// decoded. Reset clears control state only; the store needs no clearing pass, since
// every byte of a good frame is written before it is read.
module radar_target_frame_parser_unit
    import rtfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               tgt_valid,
    input  logic               tgt_stall,
    output logic [1:0]         target_number,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] target_speed,
    output logic               has_target,
    output logic               last_of_frame
);

    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              dec_busy;
    handoff_t          hand;

    // Frame collection
    rtfp_collector u_collector (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_byte  (rx_byte),
        .rx_stall (rx_stall),
        .dec_busy (dec_busy),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .hand     (hand)
    );

    // Byte store
    rtfp_frame_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Slot decoding and result register
    rtfp_decoder u_decoder (
        .clk           (clk),
        .rst_n         (rst_n),
        .hand          (hand),
        .dec_busy      (dec_busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .tgt_valid     (tgt_valid),
        .tgt_stall     (tgt_stall),
        .target_number (target_number),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .target_speed  (target_speed),
        .has_target    (has_target),
        .last_of_frame (last_of_frame)
    );

`ifndef SYNTH
    // Collector never writes the bank the decoder is reading
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr[MEM_AW-1] != rd_addr[MEM_AW-1]))
        else $error("frame store bank collision");

    // A frame is only handed over to an idle decoder
    assert property (@(posedge clk) disable iff (!rst_n)
        hand.start |-> !dec_busy)
        else $error("frame handed to busy decoder");

    // A beat with no target is always the empty-frame closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (tgt_valid && !has_target) |-> (last_of_frame && (target_number == 2'd0)))
        else $error("empty result beat malformed");
`endif

endmodule

>>> test/tb.sv
// Testbench for radar_target_frame_parser_unit: byte-stream stimulus, self-checking target beats.
// Depends on rtfp_pkg and the parser RTL; no files or arguments are read.
// A clocked driver feeds rx beats from a queue; a clocked monitor predicts and checks tgt beats.
module tb
    import rtfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTES_WANTED   = 410;
    localparam int RX_CALM_LO     = 300;
    localparam int RX_CALM_HI     = 500;
    localparam int TGT_CALM_LO    = 9;
    localparam int TGT_CALM_HI    = 15;
    localparam int HOLD_AT_RESULT = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 64;
    localparam int NO_FLAW        = -1;

    typedef struct {
        logic [7:0] val;
        bit         hold_back;   // offer only once every expected target has come out
    } rx_item_t;

    typedef struct {
        logic [1:0]         num;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] spd;
        logic               present;
        logic               last;
    } target_rpt_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               tgt_valid;
    logic               tgt_stall = 1'b0;
    logic [1:0]         target_number;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] target_speed;
    logic               has_target;
    logic               last_of_frame;

    rx_item_t    rx_pending[$];
    target_rpt_t targets_due[$];
    logic [7:0]  slot_img[24];
    logic [7:0]  rx_frame[FRAME_BYTES];
    int          sync_fill = 0;
    int          err_count = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    bit          pause_next = 1'b0;
    logic        due_empty = 1'b1;

    radar_target_frame_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .tgt_valid     (tgt_valid),
        .tgt_stall     (tgt_stall),
        .target_number (target_number),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .target_speed  (target_speed),
        .has_target    (has_target),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sign-magnitude word: bit 15 set is positive
    function automatic logic signed [15:0] sm_value(input logic [7:0] lo, input logic [7:0] hi);
        logic signed [15:0] mag;
        mag = {1'b0, hi[6:0], lo};
        return hi[7] ? mag : -mag;
    endfunction

    // Parser state machine: sync hunt, frame fill, decode of a good frame into targets_due
    task automatic parse_byte(input logic [7:0] b);
        target_rpt_t rpt;
        target_rpt_t found[3];
        int          n;
        int          base;
        if (sync_fill == 0)
        begin
            if (b == SYNC_A)
            begin
                rx_frame[0] = b;
                sync_fill = 1;
            end
        end
        else if (sync_fill == 1)
        begin
            // a broken pair drops the byte, even another 0xAA
            if (b == SYNC_B)
            begin
                rx_frame[1] = b;
                sync_fill = 2;
            end
            else
                sync_fill = 0;
        end
        else
        begin
            rx_frame[sync_fill] = b;
            sync_fill++;
            if (sync_fill == FRAME_BYTES)
            begin
                sync_fill = 0;
                if (rx_frame[0] == SYNC_A && rx_frame[1] == SYNC_B && rx_frame[2] == HDR_C &&
                    rx_frame[3] == HDR_D && rx_frame[FRAME_BYTES-2] == FOOT_A &&
                    rx_frame[FRAME_BYTES-1] == FOOT_B)
                begin
                    n = 0;
                    for (int s = 0; s < SLOT_COUNT; s++)
                    begin
                        base = 4 + 8 * s;
                        if ((rx_frame[base] | rx_frame[base+1] | rx_frame[base+2] |
                             rx_frame[base+3]) != 8'h00)
                        begin
                            rpt.num     = 2'(s + 1);
                            rpt.x       = sm_value(rx_frame[base], rx_frame[base+1]);
                            rpt.y       = sm_value(rx_frame[base+2], rx_frame[base+3]);
                            rpt.spd     = sm_value(rx_frame[base+4], rx_frame[base+5]);
                            rpt.present = 1'b1;
                            rpt.last    = 1'b0;
                            found[n] = rpt;
                            n++;
                        end
                    end
                    // empty frame: one all-zero beat
                    if (n == 0)
                    begin
                        found[0] = '{num: 2'd0, x: 16'sd0, y: 16'sd0, spd: 16'sd0,
                                     present: 1'b0, last: 1'b0};
                        n = 1;
                    end
                    found[n-1].last = 1'b1;
                    for (int k = 0; k < n; k++)
                        targets_due.insert(targets_due.size(), found[k]);
                end
            end
        end
    endtask

    function automatic void compare_field(input string name, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    task automatic push_byte(input logic [7:0] b);
        rx_item_t item;
        item.val = b;
        item.hold_back = pause_next;
        rx_pending.insert(rx_pending.size(), item);
        pause_next = 1'b0;
    endtask

    // Whole frame around slot_img, optionally with one marker byte spoilt
    task automatic push_frame(input int flaw_at);
        logic [7:0] fr[FRAME_BYTES];
        fr[0] = SYNC_A;
        fr[1] = SYNC_B;
        fr[2] = HDR_C;
        fr[3] = HDR_D;
        for (int k = 0; k < 24; k++)
            fr[4+k] = slot_img[k];
        fr[FRAME_BYTES-2] = FOOT_A;
        fr[FRAME_BYTES-1] = FOOT_B;
        if (flaw_at != NO_FLAW)
            fr[flaw_at] = fr[flaw_at] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < FRAME_BYTES; k++)
            push_byte(fr[k]);
    endtask

    // rx driver: holds a stalled beat, otherwise offers the next queued byte or idles
    always @(posedge clk)
    begin : rx_driver
        bit took;
        bit gap;
        if (!rst_n)
            rx_valid <= 1'b0;
        else
        begin
            took = rx_valid && !rx_stall;
            if (took)
            begin
                void'(rx_pending.pop_front());
                bytes_sent++;
            end
            if (!rx_valid || took)
            begin
                gap = (bytes_sent < RX_CALM_LO || bytes_sent >= RX_CALM_HI) &&
                      ($urandom_range(99) < 20);
                if (rx_pending.size() == 0 || gap)
                    rx_valid <= 1'b0;
                else if (rx_pending[0].hold_back && (took || !due_empty))
                    rx_valid <= 1'b0;
                else
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= rx_pending[0].val;
                end
            end
        end
    end

    // tgt monitor: checks beats, predicts from accepted bytes, drives stall, watchdog
    always @(posedge clk)
    begin : tgt_monitor
        target_rpt_t want;
        int          hold_left;
        bit          hold_done;
        int          quiet_cycles;
        if (!rst_n)
        begin
            tgt_stall    <= 1'b0;
            hold_left    = 0;
            hold_done    = 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            if (tgt_valid && !tgt_stall)
            begin
                results_seen++;
                if (targets_due.size() == 0)
                begin
                    $error("target beat with nothing expected: slot %0d", target_number);
                    err_count++;
                end
                else
                begin
                    want = targets_due.pop_front();
                    compare_field("target_number", want.num, target_number);
                    compare_field("pos_x", want.x, pos_x);
                    compare_field("pos_y", want.y, pos_y);
                    compare_field("target_speed", want.spd, target_speed);
                    compare_field("has_target", want.present, has_target);
                    compare_field("last_of_frame", want.last, last_of_frame);
                end
            end
            if (rx_valid && !rx_stall)
                parse_byte(rx_byte);
            due_empty <= (targets_due.size() == 0);

            // one long hold-off so the parser backs up onto rx
            if (hold_left > 0)
            begin
                hold_left--;
                tgt_stall <= 1'b1;
            end
            else if (!hold_done && results_seen == HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                tgt_stall <= 1'b1;
            end
            else if (results_seen >= TGT_CALM_LO && results_seen < TGT_CALM_HI)
                tgt_stall <= 1'b0;
            else
                tgt_stall <= ($urandom_range(99) < 20);

            if ((rx_valid && !rx_stall) || (tgt_valid && !tgt_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int good_frames;
        int pick;
        int kind;
        int flaw_pos[4];
        logic [7:0] corner[4];
        flaw_pos = '{IDX_HDR_C, IDX_HDR_D, IDX_FOOT_A, IDX_LAST};
        corner   = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        good_frames = 0;

        // Broken sync: AA 00, then AA AA FF where the second AA and the FF are dropped
        push_byte(SYNC_A);
        push_byte(8'h00);
        push_byte(SYNC_A);
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        // Extremes: +32767, -32767, +0, -1, negative zero, speed -32767
        slot_img = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
                     8'h00, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34,
                     8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'hAB, 8'hCD};
        push_frame(NO_FLAW);
        // Empty frame; speed bytes alone do not make a target
        slot_img = '{default: 8'h00};
        slot_img[4] = 8'h12;
        slot_img[5] = 8'h80;
        push_frame(NO_FLAW);
        // Only the middle slot present
        slot_img = '{default: 8'h00};
        slot_img[8]  = 8'h34;
        slot_img[9]  = 8'h92;
        slot_img[10] = 8'h00;
        slot_img[11] = 8'h80;
        slot_img[12] = 8'h05;
        push_frame(NO_FLAW);
        // Bad header and bad footer give nothing
        push_frame(IDX_HDR_D);
        push_frame(IDX_LAST);

        // Random part: mostly good frames, some spoilt, broken sync and noise
        pause_next = 1'b1;
        while (rx_pending.size() < BYTES_WANTED)
        begin
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                kind = $urandom_range(99);
                for (int k = 0; k < 8; k++)
                    slot_img[8*s+k] = 8'($urandom_range(255));
                if (kind < 25)
                begin
                    for (int k = 0; k < 4; k++)
                        slot_img[8*s+k] = 8'h00;
                end
                else if (kind < 35)
                begin
                    for (int k = 0; k < 4; k++)
                        slot_img[8*s+k] = 8'h00;
                    slot_img[8*s+$urandom_range(3)] = 8'($urandom_range(1, 255));
                end
                else if (kind < 50)
                begin
                    for (int k = 0; k < 6; k++)
                        slot_img[8*s+k] = corner[$urandom_range(3)];
                end
            end
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                push_frame(NO_FLAW);
                good_frames++;
                if (good_frames == 4)
                    pause_next = 1'b1;
            end
            else if (pick < 85)
                push_frame(flaw_pos[$urandom_range(3)]);
            else if (pick < 92)
            begin
                push_byte(SYNC_A);
                push_byte($urandom_range(1) ? SYNC_A : 8'($urandom_range(0, 254)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(255)));
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all bytes out, all targets in, then a quiet tail for stray beats
        while (rx_pending.size() != 0 || rx_valid)
            @(negedge clk);
        while (targets_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
